FILE: design/lds_pkg.sv
// shared widths, limits and state codes for the decreasing-run length core
package lds_pkg;

   localparam int SAMPLE_W      = 7;
   localparam int RUN_W         = 7;
   localparam int RUN_MAX       = 127;
   localparam int DEF_MAX_SLOTS = 64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CHECK,
      ST_FINISH
   } lds_state_type;

endpackage

FILE: design/longest_decreasing_subsequence_length_core.sv
// longest non-increasing subsequence length tracker built around a tail-slot memory
// a word is taken in idle, then the binary search alternates probe (one memory read) and
// check (one compare) steps until the window is empty; a zero value skips the search; the
// finish step waits for a free response slot, and no new word is taken until it is done
// reset: clears the fill count, the state machine and the response valid flag; slots at or
// above the fill count read as empty, so the memory itself needs no clearing pass
module longest_decreasing_subsequence_length_core #(
   parameter int MAX_SLOTS = lds_pkg::DEF_MAX_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lds_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic                        req_end_of_sequence,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lds_pkg::RUN_W-1:0]   rsp_run_length,
   output logic                        rsp_sequence_done,
   output logic                        rsp_item_rejected
);
   import lds_pkg::*;

   // address width of the slot memory and width of a count that can hold MAX_SLOTS
   localparam int AW = $clog2(MAX_SLOTS);
   localparam int LW = $clog2(MAX_SLOTS + 1);
   localparam int SW = (LW > RUN_W) ? LW : RUN_W;

   // tail per subsequence length, non-increasing from slot to slot
   logic [SAMPLE_W-1:0] tail_mem [MAX_SLOTS];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                rd_en;
   logic                wr_en;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       wr_addr;

   lds_state_type state_ff, state_in;

   // fill count: slots below it hold tails, the rest read as empty
   logic [LW-1:0]       best_length_ff, best_length_in;

   // search window [lo, hi) over the slots in use
   logic [LW-1:0]       lo_ff, lo_in;
   logic [LW-1:0]       hi_ff, hi_in;
   logic [LW:0]         mid_sum;
   logic [LW-1:0]       mid;

   // word being worked on
   logic [SAMPLE_W-1:0] value_ff, value_in;
   logic                last_ff, last_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RUN_W-1:0]    rsp_run_length_ff, rsp_run_length_in;
   logic                rsp_done_ff, rsp_done_in;
   logic                rsp_rejected_ff, rsp_rejected_in;

   // finish-step signals
   logic                rsp_free;
   logic                reject;
   logic [LW-1:0]       new_length;
   logic [SW-1:0]       len_wide;

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[LW:1];
   assign rd_addr  = mid[AW-1:0];
   assign wr_addr  = lo_ff[AW-1:0];

   // response slot can take a new word when empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // zero value or every slot already at least the value with the store full
   assign reject   = (value_ff == '0) || (lo_ff == LW'(MAX_SLOTS));

   // the value lands at lo; the length grows only when lo is the first empty slot
   always_comb begin
      new_length = best_length_ff;
      if (!reject && (lo_ff == best_length_ff)) begin
         new_length = best_length_ff + LW'(1);
      end
   end

   assign len_wide = SW'(new_length);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         best_length_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         best_length_ff <= best_length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      lo_ff             <= lo_in;
      hi_ff             <= hi_in;
      value_ff          <= value_in;
      last_ff           <= last_in;
      rsp_run_length_ff <= rsp_run_length_in;
      rsp_done_ff       <= rsp_done_in;
      rsp_rejected_ff   <= rsp_rejected_in;
   end

   // slot memory, one read and one write port, registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tail_mem[wr_addr] <= value_ff;
      end
      if (rd_en) begin
         rd_data_ff <= tail_mem[rd_addr];
      end
   end

   always_comb begin
      state_in          = state_ff;
      best_length_in    = best_length_ff;
      lo_in             = lo_ff;
      hi_in             = hi_ff;
      value_in          = value_ff;
      last_in           = last_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_run_length_in = rsp_run_length_ff;
      rsp_done_in       = rsp_done_ff;
      rsp_rejected_in   = rsp_rejected_ff;
      req_stall         = 1'b1;
      rd_en             = 1'b0;
      wr_en             = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               value_in = req_sample_value;
               last_in  = req_end_of_sequence;
               lo_in    = '0;
               hi_in    = best_length_ff;
               // a zero value skips the search altogether
               state_in = (req_sample_value == '0) ? ST_FINISH : ST_PROBE;
            end
         end

         ST_PROBE: begin
            // window empty: lo is the first slot whose tail is below the value
            if (lo_ff == hi_ff) begin
               state_in = ST_FINISH;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (rd_data_ff < value_ff) begin
               hi_in = mid;
            end else begin
               lo_in = mid + LW'(1);
            end
            state_in = ST_PROBE;
         end

         ST_FINISH: begin
            if (rsp_free) begin
               wr_en           = !reject;
               rsp_valid_in    = 1'b1;
               rsp_done_in     = last_ff;
               rsp_rejected_in = reject;
               if (len_wide > SW'(RUN_MAX)) begin
                  rsp_run_length_in = RUN_W'(RUN_MAX);
               end else begin
                  rsp_run_length_in = len_wide[RUN_W-1:0];
               end
               // end of sequence empties the store by dropping the fill count
               best_length_in = last_ff ? '0 : new_length;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_run_length    = rsp_run_length_ff;
   assign rsp_sequence_done = rsp_done_ff;
   assign rsp_item_rejected = rsp_rejected_ff;

   // fill count never passes the slot count
   assert property (@(posedge clock) disable iff (reset)
      best_length_ff <= LW'(MAX_SLOTS))
      else $error("fill count beyond slot count");

   // search window stays ordered and inside the slots in use
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE || state_ff == ST_CHECK) |->
         (lo_ff <= hi_ff && hi_ff <= best_length_ff))
      else $error("search window out of range");

   // a word closing a sequence leaves an empty store behind
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_free && last_ff) |=> (best_length_ff == '0))
      else $error("store not emptied after end of sequence");

   // an accepted value always yields a non-zero length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_rejected_ff) |-> (rsp_run_length_ff != '0))
      else $error("accepted value with zero length");

   // the memory is written only when a result is produced
   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid_ff)
      else $error("slot write without result");

endmodule

FILE: sim/longest_decreasing_subsequence_length_core_tb.sv
// testbench for the decreasing-run length core: random and directed words against a scoreboard
module longest_decreasing_subsequence_length_core_tb;
   import lds_pkg::*;

   localparam int SLOTS          = DEF_MAX_SLOTS;
   localparam int WORD_TARGET    = 1800;
   // longest quiet spell: a full-store search behind the long hold and a sender gap
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   // settle time after the last drain leaves room for any stray response
   localparam int SETTLE_CYCLES  = 40;

   typedef struct packed {
      logic [RUN_W-1:0] run_length;
      logic             done;
      logic             rejected;
   } run_result_type;

   // tail-slot predictor and the queue of results it has promised
   class decreasing_run_scoreboard;
      bit [SAMPLE_W-1:0] tails [SLOTS];
      int                fill;
      run_result_type    expected_runs [$];
      int                errors;
      int                checked;
      int                rejected_seen;
      int                longest_seen;
      int                sequences_closed;

      function void note_word(logic [SAMPLE_W-1:0] value, logic eos);
         run_result_type want;
         bit             taken;
         int             k;
         taken = 1'b0;
         // first slot whose tail lies strictly below the value takes it
         if (value != 0) begin
            for (k = 0; k < SLOTS && !taken; k++) begin
               if (tails[k] < value) begin
                  tails[k] = value;
                  if (k + 1 > fill) fill = k + 1;
                  taken = 1'b1;
               end
            end
         end
         want.run_length = RUN_W'((fill > RUN_MAX) ? RUN_MAX : fill);
         want.done       = eos;
         want.rejected   = !taken;
         expected_runs.push_back(want);
         // the result is formed first, then the store empties
         if (eos) begin
            foreach (tails[i]) tails[i] = '0;
            fill = 0;
            sequences_closed++;
         end
      endfunction

      function void check_word(logic [RUN_W-1:0] run_length, logic done, logic rejected);
         run_result_type want;
         if (expected_runs.size() == 0) begin
            $error("unexpected result word: run_length %0d", run_length);
            errors++;
            return;
         end
         want = expected_runs.pop_front();
         checked++;
         if (run_length !== want.run_length) begin
            $error("run_length: expected %0d, actual %0d", want.run_length, run_length);
            errors++;
         end
         if (done !== want.done) begin
            $error("sequence_done: expected %0b, actual %0b", want.done, done);
            errors++;
         end
         if (rejected !== want.rejected) begin
            $error("item_rejected: expected %0b, actual %0b", want.rejected, rejected);
            errors++;
         end
         if (want.rejected) rejected_seen++;
         if (want.run_length > longest_seen) longest_seen = want.run_length;
      endfunction

      function int pending();
         return expected_runs.size();
      endfunction
   endclass

   logic                clock               = 1'b0;
   logic                reset               = 1'b1;
   logic                req_valid           = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample_value    = '0;
   logic                req_end_of_sequence = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall           = 1'b0;
   logic [RUN_W-1:0]    rsp_run_length;
   logic                rsp_sequence_done;
   logic                rsp_item_rejected;

   decreasing_run_scoreboard sb;
   int  words_sent;
   int  burst_left;
   int  quiet_cycles;
   int  holds_done;
   bit  hold_active;

   longest_decreasing_subsequence_length_core #(
      .MAX_SLOTS(SLOTS)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample_value    (req_sample_value),
      .req_end_of_sequence (req_end_of_sequence),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_run_length      (rsp_run_length),
      .rsp_sequence_done   (rsp_sequence_done),
      .rsp_item_rejected   (rsp_item_rejected)
   );

   always #5 clock = ~clock;

   // result side: check each accepted word and track quiet cycles for the watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_word(rsp_run_length, rsp_sequence_done, rsp_item_rejected);
      end
   end

   // receiver: stall modes that change every so often, plus the long hold on request
   initial begin
      int mode;
      int span;
      int k;
      forever begin
         if (hold_active) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
            holds_done++;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
            for (k = 0; k < span && !hold_active; k++) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= k[0];
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // watchdog: nothing moving on either side for too long
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog expired with %0d results outstanding", sb.pending());
      $display("DONE: errors detected");
      $finish;
   end

   // sender gaps: bursts of random length, no gaps while the receiver is held off
   task automatic pace();
      if (hold_active) return;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(0, 30);
      end
   endtask

   // offer one word and hold it until taken
   task automatic send_word(input logic [SAMPLE_W-1:0] value, input logic eos);
      req_valid           <= 1'b1;
      req_sample_value    <= value;
      req_end_of_sequence <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(value, eos);
      words_sent++;
      pace();
   endtask

   // stop offering until every promised result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // one random sequence: short mixed, dense small-range, mostly falling, or loose noise
   task automatic random_sequence();
      int kind;
      int len;
      int top;
      int v;
      int i;
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
         len = $urandom_range(1, 12);
         for (i = 0; i < len; i++) begin
            v = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 127);
            send_word(SAMPLE_W'(v), i == len - 1);
         end
      end else if (kind <= 6) begin
         // few distinct values give long non-increasing runs and can fill the store
         top = $urandom_range(2, 6);
         len = $urandom_range(30, 120);
         for (i = 0; i < len; i++) begin
            v = ($urandom_range(0, 31) == 0) ? 0 : $urandom_range(1, top);
            send_word(SAMPLE_W'(v), i == len - 1);
         end
      end else if (kind == 7) begin
         len = $urandom_range(10, 70);
         v   = 127;
         for (i = 0; i < len; i++) begin
            send_word(SAMPLE_W'(v), i == len - 1);
            if ($urandom_range(0, 7) == 0) v = $urandom_range(1, 127);
            else v = (v > 3) ? v - $urandom_range(0, 3) : 1;
         end
      end else begin
         // any value, end flag at random, sequence may stay open
         len = $urandom_range(1, 4);
         for (i = 0; i < len; i++) begin
            send_word(SAMPLE_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      int i;
      int directed_words;
      bit paused;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero words, equal and rising values, alternating bit patterns
      send_word(127, 1'b1);
      send_word(0, 1'b1);
      send_word(5, 1'b0);
      send_word(0, 1'b0);
      send_word(5, 1'b0);
      send_word(6, 1'b0);
      send_word(1, 1'b0);
      send_word(127, 1'b0);
      send_word(85, 1'b0);
      send_word(42, 1'b0);
      send_word(64, 1'b0);
      send_word(63, 1'b0);
      send_word(0, 1'b1);
      send_word(1, 1'b0);
      send_word(127, 1'b1);
      // equal values fill every slot, then a full store refuses, also on the closing word
      for (i = 0; i < SLOTS; i++) send_word(1, 1'b0);
      send_word(1, 1'b0);
      send_word(1, 1'b1);
      // store must read empty again after the clear
      send_word(1, 1'b1);
      drain();
      directed_words = words_sent;

      paused = 1'b0;
      while (words_sent - directed_words < WORD_TARGET) begin
         if (holds_done == 0 && !hold_active && words_sent - directed_words > 600) begin
            hold_active = 1'b1;
         end
         if (!paused && words_sent - directed_words > 1200) begin
            drain();
            paused = 1'b1;
         end
         random_sequence();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d words, checked %0d results over %0d closed sequences",
               words_sent, sb.checked, sb.sequences_closed);
      $display("%0d words refused, longest run %0d of %0d slots, %0d long receiver hold(s)",
               sb.rejected_seen, sb.longest_seen, SLOTS, holds_done);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
